FILE: hdl/t2obs_pkg.sv
`default_nettype none

package t2obs_pkg;

    localparam int GLYPH_WIDTH = 6;
    localparam int GLYPH_BITS = GLYPH_WIDTH * 8;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [7:0] FONT_FIRST = 8'd32;
    localparam logic [7:0] FONT_LAST = 8'd123;
    localparam logic [7:0] WRAP_LIMIT = 8'd126;
    localparam logic [7:0] CMD_PAGE = 8'hB0;
    localparam logic [7:0] CMD_COL_HI = 8'h10;

    localparam logic [3:0] BEAT_PAGE = 4'd0;
    localparam logic [3:0] BEAT_COL_HI = 4'd1;
    localparam logic [3:0] BEAT_COL_LO = 4'd2;
    localparam logic [3:0] BEAT_GLYPH_0 = 4'd3;
    localparam logic [3:0] BEAT_GLYPH_1 = 4'd4;
    localparam logic [3:0] BEAT_GLYPH_2 = 4'd5;
    localparam logic [3:0] BEAT_GLYPH_3 = 4'd6;
    localparam logic [3:0] BEAT_GLYPH_4 = 4'd7;
    localparam logic [3:0] BEAT_LAST = 4'd8;

    typedef struct packed {
        logic [7:0] char_code;
        logic       set_cursor;
        logic [6:0] start_column;
        logic [2:0] start_page;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic       bad_char;
        logic       last;
    } out_word_t;

    typedef struct packed {
        logic [2:0] page;
        logic [7:0] column;
        logic       bad;
        logic [6:0] glyph_idx;
    } job_t;

    typedef struct packed {
        logic push;
        logic full;
    } q_wr_t;

    typedef logic [GLYPH_BITS-1:0] glyph_t;

    function automatic glyph_t font_glyph(input logic [6:0] idx);
        glyph_t g;
        g = '0;
        case (idx)
            7'd0:  g = 48'h000000000000;
            7'd1:  g = 48'h0000002f0000;
            7'd2:  g = 48'h000007000700;
            7'd3:  g = 48'h00147f147f14;
            7'd4:  g = 48'h00242a7f2a12;
            7'd5:  g = 48'h006264081323;
            7'd6:  g = 48'h003649552250;
            7'd7:  g = 48'h000005030000;
            7'd8:  g = 48'h00001c224100;
            7'd9:  g = 48'h000041221c00;
            7'd10: g = 48'h0014083e0814;
            7'd11: g = 48'h0008083e0808;
            7'd12: g = 48'h000000a06000;
            7'd13: g = 48'h000808080808;
            7'd14: g = 48'h000060600000;
            7'd15: g = 48'h002010080402;
            7'd16: g = 48'h003e5149453e;
            7'd17: g = 48'h0000427f4000;
            7'd18: g = 48'h004261514946;
            7'd19: g = 48'h002141454b31;
            7'd20: g = 48'h001814127f10;
            7'd21: g = 48'h002745454539;
            7'd22: g = 48'h003c4a494930;
            7'd23: g = 48'h000171090503;
            7'd24: g = 48'h003649494936;
            7'd25: g = 48'h00064949291e;
            7'd26: g = 48'h000036360000;
            7'd27: g = 48'h000056360000;
            7'd28: g = 48'h000814224100;
            7'd29: g = 48'h001414141414;
            7'd30: g = 48'h000041221408;
            7'd31: g = 48'h000201510906;
            7'd32: g = 48'h00324959513e;
            7'd33: g = 48'h007c1211127c;
            7'd34: g = 48'h007f49494936;
            7'd35: g = 48'h003e41414122;
            7'd36: g = 48'h007f4141221c;
            7'd37: g = 48'h007f49494941;
            7'd38: g = 48'h007f09090901;
            7'd39: g = 48'h003e4149497a;
            7'd40: g = 48'h007f0808087f;
            7'd41: g = 48'h0000417f4100;
            7'd42: g = 48'h002040413f01;
            7'd43: g = 48'h007f08142241;
            7'd44: g = 48'h007f40404040;
            7'd45: g = 48'h007f020c027f;
            7'd46: g = 48'h007f0408107f;
            7'd47: g = 48'h003e4141413e;
            7'd48: g = 48'h007f09090906;
            7'd49: g = 48'h003e4151215e;
            7'd50: g = 48'h007f09192946;
            7'd51: g = 48'h004649494931;
            7'd52: g = 48'h0001017f0101;
            7'd53: g = 48'h003f4040403f;
            7'd54: g = 48'h001f2040201f;
            7'd55: g = 48'h003f4038403f;
            7'd56: g = 48'h006314081463;
            7'd57: g = 48'h000708700807;
            7'd58: g = 48'h006151494543;
            7'd59: g = 48'h00007f414100;
            7'd60: g = 48'h00552a552a55;
            7'd61: g = 48'h000041417f00;
            7'd62: g = 48'h000402010204;
            7'd63: g = 48'h004040404040;
            7'd64: g = 48'h000001020400;
            7'd65: g = 48'h002054545478;
            7'd66: g = 48'h007f48444438;
            7'd67: g = 48'h003844444420;
            7'd68: g = 48'h00384444487f;
            7'd69: g = 48'h003854545418;
            7'd70: g = 48'h00087e090102;
            7'd71: g = 48'h0018a4a4a47c;
            7'd72: g = 48'h007f08040478;
            7'd73: g = 48'h0000447d4000;
            7'd74: g = 48'h004080847d00;
            7'd75: g = 48'h007f10284400;
            7'd76: g = 48'h0000417f4000;
            7'd77: g = 48'h007c04180478;
            7'd78: g = 48'h007c08040478;
            7'd79: g = 48'h003844444438;
            7'd80: g = 48'h00fc24242418;
            7'd81: g = 48'h0018242418fc;
            7'd82: g = 48'h007c08040408;
            7'd83: g = 48'h004854545420;
            7'd84: g = 48'h00043f444020;
            7'd85: g = 48'h003c4040207c;
            7'd86: g = 48'h001c2040201c;
            7'd87: g = 48'h003c4030403c;
            7'd88: g = 48'h004428102844;
            7'd89: g = 48'h001ca0a0a07c;
            7'd90: g = 48'h004464544c44;
            7'd91: g = 48'h141414141414;
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/t2obs_front.sv
`default_nettype none

module t2obs_front
    import t2obs_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_word_t s_data,
    input  wire logic     q_full,
    output logic          q_push,
    output job_t          q_job
);

    logic [7:0] col_reg;
    logic [7:0] col_next;
    logic [2:0] page_reg;
    logic [2:0] page_next;
    logic [7:0] col_cur;
    logic [2:0] page_cur;
    logic       bad;

    always_comb begin
        col_cur = col_reg;
        page_cur = page_reg;
        if (s_data.set_cursor) begin
            col_cur = {1'b0, s_data.start_column};
            page_cur = s_data.start_page;
        end
        if (col_cur > WRAP_LIMIT) begin
            col_cur = '0;
            page_cur = page_cur + 3'd1;
        end

        bad = !(s_data.char_code inside {[FONT_FIRST:FONT_LAST]});

        s_ready = !q_full;
        q_push = s_valid && s_ready;

        q_job.page = page_cur;
        q_job.column = col_cur;
        q_job.bad = bad;
        q_job.glyph_idx = bad ? 7'd0 : 7'(s_data.char_code - FONT_FIRST);

        col_next = col_reg;
        page_next = page_reg;
        if (q_push) begin
            col_next = col_cur + 8'(GLYPH_WIDTH);
            page_next = page_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            page_reg <= '0;
        end else begin
            col_reg <= col_next;
            page_reg <= page_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/t2obs_queue.sv
`default_nettype none

module t2obs_queue
    import t2obs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  wire job_t  push_job,
    output q_wr_t      wr_status,
    input  wire logic  pop,
    output logic       head_valid,
    output job_t       head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_END = PTR_W'(DEPTH - 1);
    localparam logic [PTR_W-1:0] PTR_ONE = PTR_W'(1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    job_t             slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    always_comb begin
        wr_status.full = (count_reg == CNT_FULL);
        wr_status.push = push;
        head_valid = (count_reg != '0);
        head_job = slots_reg[rd_ptr_reg];

        do_push = push && !wr_status.full;
        do_pop = pop && head_valid;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_END) ? '0 : wr_ptr_reg + PTR_ONE;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_END) ? '0 : rd_ptr_reg + PTR_ONE;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_ONE;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_ONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/t2obs_back.sv
`default_nettype none

module t2obs_back
    import t2obs_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic q_valid,
    input  wire job_t q_job,
    output logic      q_pop,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_word_t m_data
);

    logic       busy_reg;
    logic       busy_next;
    logic [3:0] beat_reg;
    logic [3:0] beat_next;
    job_t       job_reg;
    job_t       job_next;
    glyph_t     glyph_reg;
    glyph_t     glyph_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    out_word_t  m_data_reg;
    out_word_t  m_data_next;
    logic       load_out;
    logic       advance;
    logic       last_beat;
    logic [7:0] glyph_byte;

    always_comb begin
        load_out = !m_valid_reg || m_ready;
        advance = busy_reg && load_out;
        last_beat = (beat_reg == BEAT_LAST);
        q_pop = q_valid && (!busy_reg || (advance && last_beat));

        busy_next = busy_reg;
        beat_next = beat_reg;
        job_next = job_reg;
        glyph_next = glyph_reg;
        if (q_pop) begin
            busy_next = 1'b1;
            beat_next = BEAT_PAGE;
            job_next = q_job;
            glyph_next = font_glyph(q_job.glyph_idx);
        end else if (advance) begin
            if (last_beat) begin
                busy_next = 1'b0;
            end
            beat_next = beat_reg + 4'd1;
        end

        glyph_byte = '0;
        case (beat_reg)
            BEAT_GLYPH_0: glyph_byte = glyph_reg[47:40];
            BEAT_GLYPH_1: glyph_byte = glyph_reg[39:32];
            BEAT_GLYPH_2: glyph_byte = glyph_reg[31:24];
            BEAT_GLYPH_3: glyph_byte = glyph_reg[23:16];
            BEAT_GLYPH_4: glyph_byte = glyph_reg[15:8];
            BEAT_LAST:    glyph_byte = glyph_reg[7:0];
            default:      glyph_byte = '0;
        endcase

        m_data_next = m_data_reg;
        if (advance) begin
            m_data_next.bad_char = job_reg.bad;
            m_data_next.last = last_beat;
            m_data_next.is_data = 1'b1;
            m_data_next.out_byte = job_reg.bad ? 8'd0 : glyph_byte;
            case (beat_reg)
                BEAT_PAGE: begin
                    m_data_next.is_data = 1'b0;
                    m_data_next.out_byte = CMD_PAGE + {5'd0, job_reg.page};
                end
                BEAT_COL_HI: begin
                    m_data_next.is_data = 1'b0;
                    m_data_next.out_byte = CMD_COL_HI | {4'd0, job_reg.column[7:4]};
                end
                BEAT_COL_LO: begin
                    m_data_next.is_data = 1'b0;
                    m_data_next.out_byte = {4'd0, job_reg.column[3:0]};
                end
                default: begin
                end
            endcase
        end

        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end

        m_valid = m_valid_reg;
        m_data = m_data_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            beat_reg <= BEAT_PAGE;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            beat_reg <= beat_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg <= job_next;
        glyph_reg <= glyph_next;
        m_data_reg <= m_data_next;
    end

endmodule

`default_nettype wire

FILE: hdl/text_to_oled_byte_stream_top.sv
// Renders one character per input word into nine output words for a page-addressed
// OLED controller: page command, high and low column commands, then six glyph columns
// from the built-in 6x8 font. The cursor wraps to the next line past column 126 and
// the page wraps from 7 to 0. The output carries one word per cycle while the sink is
// ready, paced by the back end's beat counter; with a ready sink and a queued next
// character the output runs without gaps. Input words are taken one per cycle into a
// small job queue (QUEUE_DEPTH entries) until it fills. An accepted word passes through
// a queue slot and the back end's job register before the output register. Codes
// outside 32 to 123 send a blank glyph with bad_char set on all nine words.
`default_nettype none

module text_to_oled_byte_stream_top
    import t2obs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_word_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output out_word_t     m_data
);

    q_wr_t wr_status;
    logic  push;
    job_t  push_job;
    logic  pop;
    logic  head_valid;
    job_t  head_job;

    t2obs_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (wr_status.full),
        .q_push  (push),
        .q_job   (push_job)
    );

    t2obs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .wr_status  (wr_status),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    t2obs_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (head_valid),
        .q_job   (head_job),
        .q_pop   (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire
